// ===== rtl/ksca_pkg.sv =====
// ----------------------------------------------------------------------------
// ksca_pkg
// Shared constants, key table and register codes for the keypad scan core.
// ----------------------------------------------------------------------------
`default_nettype none

package ksca_pkg;

  localparam int KEY_COUNT  = 12;
  localparam int TABLE_SIZE = 12;
  localparam int TABLE_LEN  = (KEY_COUNT < TABLE_SIZE) ? KEY_COUNT : TABLE_SIZE;

  localparam int KEY_W   = 12;
  localparam int INDEX_W = 4;

  localparam logic [KEY_W-1:0] KEY_BITS     = 12'hFFF;
  localparam int               REMOTE_POS   = 18;
  localparam int               WPROTECT_POS = 17;

  localparam logic [15:0]        FIRST_DELAY_RST  = 16'd500;
  localparam logic [15:0]        REPEAT_DELAY_RST = 16'd175;
  localparam logic [INDEX_W-1:0] ALT_KEY_RST      = 4'd12;
  localparam logic [15:0]        RUN_MAX          = 16'hFFFF;

  // key masks in table order, index 1 at position 0
  localparam logic [KEY_W-1:0] KEY_MASKS [TABLE_SIZE] = '{
    12'h003, 12'h001, 12'h080, 12'h040, 12'h010, 12'h020,
    12'h100, 12'h004, 12'h008, 12'h400, 12'h200, 12'h800
  };

  typedef enum logic [1:0] {
    REG_FIRST_DELAY  = 2'd0,
    REG_REPEAT_DELAY = 2'd1,
    REG_ALT_KEY      = 2'd2,
    REG_REMOTE_EN    = 2'd3
  } cfg_reg_t;

  // mask of a 1-based key index, zero when the index names no entry
  function automatic logic [KEY_W-1:0] key_mask(input logic [INDEX_W-1:0] k);
    logic [KEY_W-1:0] m;
    m = '0;
    if (k != '0 && 32'(k) <= TABLE_LEN) begin
      m = KEY_MASKS[k - INDEX_W'(1)];
    end
    return m;
  endfunction

  // lowest 1-based index whose hit bit is set, zero when none
  function automatic logic [INDEX_W-1:0] first_hit(input logic [TABLE_LEN-1:0] hit);
    logic [INDEX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_LEN - 1; i >= 0; i--) begin
      if (hit[i]) begin
        idx = INDEX_W'(i + 1);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/key_scan_click_autorepeat_core.sv =====
// ----------------------------------------------------------------------------
// key_scan_click_autorepeat_core
// Keypad scan decoder: pressed / clicked / autorepeat keys and remote timer.
// ----------------------------------------------------------------------------
// One scan per clock cycle is taken while the output is not stalled: a
// scan goes into an input register, all key search, autorepeat timing and
// remote run counting happen in one pass of logic, and the result lands in
// the output register. The key state carried between scans is updated in
// the same cycle that the result register is loaded, so consecutive scans
// follow each other without gaps. Configuration registers are written over
// the APB port and read back at the same addresses (4 bytes apart).
`default_nettype none

module key_scan_click_autorepeat_core import ksca_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // scan input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_raw_status,
  input  wire logic [31:0] in_time_ms,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_status_word,
  output logic [3:0]       out_pressed_key,
  output logic [3:0]       out_clicked_key,
  output logic [3:0]       out_repeat_key,
  output logic             out_remote_level,
  output logic [15:0]      out_remote_pulse_scans,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [15:0]        first_delay_r;
  logic [15:0]        repeat_delay_r;
  logic [INDEX_W-1:0] alt_key_r;
  logic               remote_en_r;

  cfg_reg_t cfg_sel;
  logic     cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_delay_r  <= FIRST_DELAY_RST;
      repeat_delay_r <= REPEAT_DELAY_RST;
      alt_key_r      <= ALT_KEY_RST;
      remote_en_r    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_FIRST_DELAY:  first_delay_r  <= pwdata[15:0];
        REG_REPEAT_DELAY: repeat_delay_r <= pwdata[15:0];
        REG_ALT_KEY:      alt_key_r      <= pwdata[INDEX_W-1:0];
        REG_REMOTE_EN:    remote_en_r    <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_FIRST_DELAY:  prdata = {16'd0, first_delay_r};
      REG_REPEAT_DELAY: prdata = {16'd0, repeat_delay_r};
      REG_ALT_KEY:      prdata = {{(32-INDEX_W){1'b0}}, alt_key_r};
      REG_REMOTE_EN:    prdata = {31'd0, remote_en_r};
      default:          prdata = '0;
    endcase
  end

  // input register and handshake
  logic        s1_valid_r;
  logic [31:0] s1_raw_r;
  logic [31:0] s1_time_r;
  logic        out_valid_r;
  logic        advance;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_raw_r  <= in_raw_status;
      s1_time_r <= in_time_ms;
    end
  end

  // scan state
  logic [KEY_W-1:0]   cur_keys_r;
  logic [INDEX_W-1:0] held_key_r;
  logic [31:0]        held_since_r;
  logic               has_repeated_r;
  logic [15:0]        remote_run_r;

  logic [KEY_W-1:0]   keys_nxt;
  logic [INDEX_W-1:0] held_key_nxt;
  logic [31:0]        held_since_nxt;
  logic               has_repeated_nxt;
  logic [15:0]        remote_run_nxt;

  logic [31:0]          status_nxt;
  logic [TABLE_LEN-1:0] down_hit;
  logic [TABLE_LEN-1:0] click_hit;
  logic [INDEX_W-1:0]   pressed_nxt;
  logic [INDEX_W-1:0]   clicked_nxt;
  logic [INDEX_W-1:0]   repeat_nxt;
  logic                 level_nxt;
  logic [15:0]          pulse_nxt;
  logic [KEY_W-1:0]     held_mask;
  logic                 held_down;
  logic [31:0]          elapsed;
  logic [15:0]          delay;

  assign keys_nxt = s1_raw_r[KEY_W-1:0];

  always_comb begin
    for (int i = 0; i < TABLE_LEN; i++) begin
      down_hit[i]  = (keys_nxt & KEY_MASKS[i]) == '0;
      click_hit[i] = down_hit[i] && ((cur_keys_r & KEY_MASKS[i]) != '0);
    end
  end

  assign pressed_nxt = first_hit(down_hit);
  assign clicked_nxt = first_hit(click_hit);

  assign held_mask = key_mask(held_key_r);
  assign held_down = (held_mask != '0) && ((keys_nxt & held_mask) == '0);
  assign elapsed   = s1_time_r - held_since_r;
  assign delay     = has_repeated_r ? repeat_delay_r : first_delay_r;

  always_comb begin
    held_key_nxt     = held_key_r;
    held_since_nxt   = held_since_r;
    has_repeated_nxt = has_repeated_r;
    repeat_nxt       = '0;
    priority if (clicked_nxt != '0) begin
      held_key_nxt     = clicked_nxt;
      has_repeated_nxt = 1'b0;
      held_since_nxt   = s1_time_r;
      repeat_nxt       = clicked_nxt;
    end else if (held_down) begin
      // elapsed read as signed: a time running backwards never fires
      if (!elapsed[31] && (elapsed > {16'd0, delay})) begin
        has_repeated_nxt = 1'b1;
        held_since_nxt   = s1_time_r;
        repeat_nxt       = held_key_r;
      end
    end else begin
      held_key_nxt = '0;
    end
  end

  assign level_nxt = s1_raw_r[REMOTE_POS];

  always_comb begin
    remote_run_nxt = remote_run_r;
    pulse_nxt      = '0;
    if (level_nxt) begin
      if (remote_run_r != RUN_MAX) begin
        remote_run_nxt = remote_run_r + 16'd1;
      end
    end else if (remote_run_r != '0) begin
      pulse_nxt      = remote_run_r;
      remote_run_nxt = '0;
    end
  end

  always_comb begin
    status_nxt = s1_raw_r | {{(32-KEY_W){1'b0}}, key_mask(alt_key_r)};
    status_nxt[WPROTECT_POS] = 1'b0;
    if (remote_en_r) begin
      status_nxt[REMOTE_POS] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_keys_r     <= KEY_BITS;
      held_key_r     <= '0;
      held_since_r   <= '0;
      has_repeated_r <= 1'b0;
      remote_run_r   <= '0;
    end else if (advance) begin
      cur_keys_r     <= keys_nxt;
      held_key_r     <= held_key_nxt;
      held_since_r   <= held_since_nxt;
      has_repeated_r <= has_repeated_nxt;
      remote_run_r   <= remote_run_nxt;
    end
  end

  // result register
  logic [31:0]        status_r;
  logic [INDEX_W-1:0] pressed_r;
  logic [INDEX_W-1:0] clicked_r;
  logic [INDEX_W-1:0] repeat_r;
  logic               level_r;
  logic [15:0]        pulse_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status_r  <= status_nxt;
      pressed_r <= pressed_nxt;
      clicked_r <= clicked_nxt;
      repeat_r  <= repeat_nxt;
      level_r   <= level_nxt;
      pulse_r   <= pulse_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status_word        = status_r;
  assign out_pressed_key        = pressed_r;
  assign out_clicked_key        = clicked_r;
  assign out_repeat_key         = repeat_r;
  assign out_remote_level       = level_r;
  assign out_remote_pulse_scans = pulse_r;

  // a click always shows up as the autorepeat key of the same transaction
  a_click_repeats: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_clicked_key != '0) |-> out_repeat_key == out_clicked_key)
    else $error("clicked key not reported as repeat key");

  // a clicked key is pressed, so some pressed key no later in the table exists
  a_click_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_clicked_key != '0) |->
      (out_pressed_key != '0) && (out_pressed_key <= out_clicked_key))
    else $error("clicked key without pressed key");

  // a remote pulse length is reported only on a scan with the line low
  a_pulse_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_remote_pulse_scans != '0) |-> !out_remote_level)
    else $error("remote pulse reported while line high");

  // a transaction leaving the input register always lands in the result register
  a_advance_loads: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded");

  // no autorepeat without a held key after the update
  a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (repeat_nxt != '0) |=> held_key_r == $past(repeat_nxt))
    else $error("repeat key not held");

endmodule

`default_nettype wire
